### rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the item and result
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int TCOL_W = 7;
    localparam int TROW_W = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NULL      = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_ERASE,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [CHAR_W-1:0] char_code;
        logic [TCOL_W-1:0] target_column;
        logic [TROW_W-1:0] target_row;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_out_item;

endpackage

### rtl/text_console_writer_unit.sv
// Text console writer: frame store, cursor and command sequencer.
//
// Usage: drive i_item and raise start; the item is taken at a rising edge
// where start is high and busy is low. Each item gives one result on
// o_result, shown for exactly one cycle with o_result_strobe high; the
// receiver cannot stall it. The attribute register is written through
// i_cfg_we / i_cfg_wdata and takes effect for later items.
// From acceptance, set cursor, newline without scroll and a null write go
// straight to the done step that raises the strobe; a character write,
// backspace or cell read first stores, erases or reads a cell; clear first
// fills every cell; a newline that scrolls, or a character write that
// scrolls after storing, first scrolls and refills the bottom row. Busy
// falls as the strobe rises, so the next item can be taken at the edge that
// ends the strobe. The frame store has one write and one read port, and
// clear and scroll sweep every cell, one cell per cycle; a scroll reads and
// writes in the same cycle.
// After reset the block sweeps all COLUMNS*ROWS cells to blank (space,
// attribute 0x0F) and holds busy high during that sweep;
// attribute writes are taken during that pass.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  tcw_pkg::t_in_item           i_item,
    output logic                        busy,
    output logic                        o_result_strobe,
    output tcw_pkg::t_out_item          o_result,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int PW         = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
    localparam int SCROLL_END = CELLS - COLUMNS;

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] CNT_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0] CNT_SCEND = AW'(SCROLL_END);
    localparam logic [tcw_pkg::CELL_W-1:0] RESET_BLANK =
        {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};

    // Frame store
    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_cmd   r_cmd, n_cmd;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_trow, n_trow;
    logic [CW-1:0]   r_tcol, n_tcol;
    logic [tcw_pkg::CHAR_W-1:0] r_ch, n_ch;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [tcw_pkg::CELL_W-1:0] r_fill, n_fill;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_scr, n_scr;
    logic            r_strobe, n_strobe;
    tcw_pkg::t_out_item r_res, n_res;

    logic                       accept;
    logic                       put_wrap;
    logic                       at_bottom;
    logic [RW-1:0]              m_row;
    logic [CW-1:0]              m_col;
    logic [PW-1:0]              lin;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;

    assign busy            = (r_state != tcw_pkg::S_IDLE);
    assign accept          = start && !busy;
    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;
    assign at_bottom       = (r_row == ROW_LAST);
    assign put_wrap        = (r_col == COL_LAST);

    // Shared linear address unit: row * COLUMNS + column
    always_comb begin
        if (r_state == tcw_pkg::S_READ) begin
            m_row = r_trow;
            m_col = r_tcol;
        end else begin
            m_row = r_row;
            m_col = r_col;
        end
        lin = PW'(m_row) * PW'(COLUMNS) + PW'(m_col);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_INIT: begin
                if (r_cnt == CNT_LAST) n_state = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.command)
                        tcw_pkg::CMD_WRITE: begin
                            if (i_item.char_code == tcw_pkg::CH_NULL) begin
                                n_state = tcw_pkg::S_DONE;
                            end else if (i_item.char_code == tcw_pkg::CH_NEWLINE) begin
                                n_state = at_bottom ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
                            end else if (i_item.char_code == tcw_pkg::CH_BACKSPACE) begin
                                n_state = tcw_pkg::S_ERASE;
                            end else begin
                                n_state = tcw_pkg::S_PUT;
                            end
                        end
                        tcw_pkg::CMD_SET:   n_state = tcw_pkg::S_DONE;
                        tcw_pkg::CMD_CLEAR: n_state = tcw_pkg::S_FILL;
                        tcw_pkg::CMD_READ:  n_state = tcw_pkg::S_READ;
                        default:            n_state = tcw_pkg::S_DONE;
                    endcase
                end
            end
            tcw_pkg::S_PUT: begin
                n_state = (put_wrap && at_bottom) ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
            end
            tcw_pkg::S_ERASE:  n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_READ:   n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_SCROLL: begin
                if (r_cnt == CNT_SCEND) n_state = tcw_pkg::S_FILL;
            end
            tcw_pkg::S_FILL: begin
                if (r_cnt == CNT_LAST) n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE:   n_state = tcw_pkg::S_IDLE;
            default:           n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // Datapath and frame store controls
    always_comb begin
        n_cmd     = r_cmd;
        n_row     = r_row;
        n_col     = r_col;
        n_trow    = r_trow;
        n_tcol    = r_tcol;
        n_ch      = r_ch;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_scr     = r_scr;
        n_strobe  = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_cnt;
        mem_raddr = r_cnt + AW'(COLUMNS);
        mem_wdata = r_fill;
        case (r_state)
            tcw_pkg::S_INIT: begin
                // blank one cell per cycle after reset
                mem_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
            end
            tcw_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_item.command;
                    n_ch   = i_item.char_code;
                    n_scr  = 1'b0;
                    n_cnt  = '0;
                    n_fill = {r_attr, tcw_pkg::CH_SPACE};
                    // saturate the target to the screen
                    if (int'(i_item.target_column) >= COLUMNS) n_tcol = COL_LAST;
                    else n_tcol = CW'(i_item.target_column);
                    if (int'(i_item.target_row) >= ROWS) n_trow = ROW_LAST;
                    else n_trow = RW'(i_item.target_row);
                    case (i_item.command)
                        tcw_pkg::CMD_WRITE: begin
                            if (i_item.char_code == tcw_pkg::CH_NEWLINE) begin
                                n_col = '0;
                                if (at_bottom) n_scr = 1'b1;
                                else n_row = r_row + RW'(1);
                            end else if (i_item.char_code == tcw_pkg::CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col = r_col - CW'(1);
                                end else if (r_row != '0) begin
                                    n_row = r_row - RW'(1);
                                    n_col = COL_LAST;
                                end
                            end
                        end
                        tcw_pkg::CMD_SET: begin
                            n_col = (int'(i_item.target_column) >= COLUMNS) ?
                                    COL_LAST : CW'(i_item.target_column);
                            n_row = (int'(i_item.target_row) >= ROWS) ?
                                    ROW_LAST : RW'(i_item.target_row);
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcw_pkg::S_PUT: begin
                // store the character, then advance the cursor
                mem_we    = 1'b1;
                mem_waddr = lin[AW-1:0];
                mem_wdata = {r_attr, r_ch};
                if (put_wrap) begin
                    n_col = '0;
                    if (at_bottom) n_scr = 1'b1;
                    else n_row = r_row + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            tcw_pkg::S_ERASE: begin
                mem_we    = 1'b1;
                mem_waddr = lin[AW-1:0];
                mem_wdata = {r_attr, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = lin[AW-1:0];
            end
            tcw_pkg::S_SCROLL: begin
                // read a row below, write back the cell read last cycle
                mem_re    = (r_cnt != CNT_SCEND);
                mem_we    = (r_cnt != '0);
                mem_waddr = r_cnt - AW'(1);
                mem_wdata = r_rdata;
                if (r_cnt != CNT_SCEND) n_cnt = r_cnt + AW'(1);
            end
            tcw_pkg::S_FILL: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
            end
            tcw_pkg::S_DONE: begin
                n_strobe                = 1'b1;
                n_res.cursor_position   = lin[tcw_pkg::POS_W-1:0];
                n_res.cell_value        = (r_cmd == tcw_pkg::CMD_READ) ? r_rdata : '0;
                n_res.scrolled          = r_scr;
            end
            default: begin
            end
        endcase
    end

    // Frame store ports
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::S_INIT;
            r_row    <= '0;
            r_col    <= '0;
            r_cnt    <= '0;
            r_fill   <= RESET_BLANK;
            r_scr    <= 1'b0;
            r_strobe <= 1'b0;
            r_cmd    <= tcw_pkg::CMD_WRITE;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_scr    <= n_scr;
            r_strobe <= n_strobe;
            r_cmd    <= n_cmd;
        end
    end

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_trow <= n_trow;
        r_tcol <= n_tcol;
        r_ch   <= n_ch;
        r_res  <= n_res;
    end

endmodule
